>>> src/sed_pkg.sv
// Package for the string escape decoder: decoder modes, result record and
// character constants. No dependencies.
`default_nettype none

package sed_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_DEC    = 3'd3,
        MODE_ERR    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       failed;
        logic       last_in_run;
    } t_result;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    localparam logic [15:0] DEC_MAX = 16'd255;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] f_hex_digit(input logic [7:0] b);
        logic [7:0] t;
        t = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            t = b - CH_0;
            return {1'b1, t[3:0]};
        end else if (b >= CH_LA && b <= CH_LF_HEX) begin
            t = b - CH_LA + 8'd10;
            return {1'b1, t[3:0]};
        end else if (b >= CH_UA && b <= CH_UF) begin
            t = b - CH_UA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic f_is_dec(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic t_result f_data(input logic [7:0] b);
        return '{out_byte: b, kind: 1'b0, failed: 1'b0, last_in_run: 1'b0};
    endfunction

    function automatic t_result f_status(input logic fail);
        return '{out_byte: 8'd0, kind: 1'b1, failed: fail, last_in_run: 1'b0};
    endfunction

endpackage

`default_nettype wire

>>> src/string_escape_decoder_unit.sv
// String escape decoder top level: per-item decode step and result queue.
// Depends on sed_pkg.
// An accepted item is decoded in the cycle it is taken and its zero to three results are
// written at once into a four-entry result queue, which delivers one result per cycle while
// the output is not stalled. The input takes a new item every cycle while the queue holds at
// most one result, so a stream of one-result items runs at one item per cycle when the output
// does not stall; an item that gives two or three results (a closed hex or decimal escape, a brace escape,
// an end item that flushes an escape) holds the input while the queue drains through the single output port.
`default_nettype none

module string_escape_decoder_unit
    import sed_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_marker,
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [7:0] o_out_byte,
    output      logic       o_kind,
    output      logic       o_failed,
    output      logic       o_last_in_run
);

    localparam int DEPTH = 4;

    t_mode       r_mode, n_mode;
    logic [15:0] r_val, n_val;
    logic [2:0]  r_cnt, n_cnt;

    t_result     step_res [3];
    logic [1:0]  step_n;
    logic [4:0]  hex_d;
    logic [15:0] dec_acc;

    t_result     r_fifo [DEPTH];
    logic [1:0]  r_head, r_tail;
    logic [2:0]  r_count;

    logic        in_acc, out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign hex_d   = f_hex_digit(i_in_byte);
    assign dec_acc = {r_val[12:0], 3'b000} + {r_val[14:0], 1'b0}
                   + {8'd0, i_in_byte - CH_0};

    // Decode step: mirrors the escape rules in sequence, emitting into step_res.
    always_comb begin
        n_mode = r_mode;
        n_val  = r_val;
        n_cnt  = r_cnt;
        step_n = 2'd0;
        for (int i = 0; i < 3; i++) begin
            step_res[i] = f_data(8'd0);
        end

        if (i_end_marker) begin
            if (r_mode == MODE_HEX) begin
                if (r_cnt == 3'd2) begin
                    step_res[step_n] = f_data(r_val[7:0]);
                    step_n = step_n + 2'd1;
                    n_mode = MODE_NORMAL;
                end else if (r_cnt == 3'd4) begin
                    step_res[step_n] = f_data(r_val[15:8]);
                    step_n = step_n + 2'd1;
                    step_res[step_n] = f_data(r_val[7:0]);
                    step_n = step_n + 2'd1;
                    n_mode = MODE_NORMAL;
                end else begin
                    n_mode = MODE_ERR;
                end
            end else if (r_mode == MODE_DEC) begin
                if (r_val > DEC_MAX) begin
                    n_mode = MODE_ERR;
                end else begin
                    step_res[step_n] = f_data(r_val[7:0]);
                    step_n = step_n + 2'd1;
                    n_mode = MODE_NORMAL;
                end
            end
            step_res[step_n] = f_status(n_mode == MODE_ERR);
            step_n = step_n + 2'd1;
            n_mode = MODE_NORMAL;
            n_val  = 16'd0;
            n_cnt  = 3'd0;
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_NORMAL;
                    case (i_in_byte)
                        CH_N: begin
                            step_res[0] = f_data(CH_LF);
                            step_n = 2'd1;
                        end
                        CH_T: begin
                            step_res[0] = f_data(CH_TAB);
                            step_n = 2'd1;
                        end
                        CH_BSLASH, CH_DQUOTE, CH_SQUOTE: begin
                            step_res[0] = f_data(i_in_byte);
                            step_n = 2'd1;
                        end
                        CH_LBRACE: begin
                            step_res[0] = f_data(CH_BSLASH);
                            step_res[1] = f_data(CH_LBRACE);
                            step_n = 2'd2;
                        end
                        CH_X: begin
                            n_mode = MODE_HEX;
                            n_val  = 16'd0;
                            n_cnt  = 3'd0;
                        end
                        default: begin
                            if (f_is_dec(i_in_byte)) begin
                                n_mode = MODE_DEC;
                                n_val  = {8'd0, i_in_byte - CH_0};
                                n_cnt  = 3'd1;
                            end
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (hex_d[4]) begin
                        n_val = {r_val[11:0], hex_d[3:0]};
                        n_cnt = r_cnt + 3'd1;
                        if (n_cnt >= 3'd5) begin
                            n_mode = MODE_ERR;
                        end
                    end else begin
                        if (r_cnt == 3'd2) begin
                            step_res[step_n] = f_data(r_val[7:0]);
                            step_n = step_n + 2'd1;
                            n_mode = MODE_NORMAL;
                        end else if (r_cnt == 3'd4) begin
                            step_res[step_n] = f_data(r_val[15:8]);
                            step_n = step_n + 2'd1;
                            step_res[step_n] = f_data(r_val[7:0]);
                            step_n = step_n + 2'd1;
                            n_mode = MODE_NORMAL;
                        end else begin
                            n_mode = MODE_ERR;
                        end
                        if (n_mode != MODE_ERR) begin
                            if (i_in_byte == CH_BSLASH) begin
                                n_mode = MODE_ESC;
                            end else begin
                                step_res[step_n] = f_data(i_in_byte);
                                step_n = step_n + 2'd1;
                            end
                        end
                    end
                end
                MODE_DEC: begin
                    if (f_is_dec(i_in_byte)) begin
                        n_val = dec_acc;
                        n_cnt = r_cnt + 3'd1;
                        if (n_cnt >= 3'd3) begin
                            if (dec_acc > DEC_MAX) begin
                                n_mode = MODE_ERR;
                            end else begin
                                step_res[0] = f_data(dec_acc[7:0]);
                                step_n = 2'd1;
                                n_mode = MODE_NORMAL;
                            end
                        end
                    end else begin
                        if (r_val > DEC_MAX) begin
                            n_mode = MODE_ERR;
                        end else begin
                            step_res[step_n] = f_data(r_val[7:0]);
                            step_n = step_n + 2'd1;
                            n_mode = MODE_NORMAL;
                            if (i_in_byte == CH_BSLASH) begin
                                n_mode = MODE_ESC;
                            end else begin
                                step_res[step_n] = f_data(i_in_byte);
                                step_n = step_n + 2'd1;
                            end
                        end
                    end
                end
                MODE_ERR: begin
                end
                default: begin
                    n_mode = MODE_NORMAL;
                    if (i_in_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        step_res[0] = f_data(i_in_byte);
                        step_n = 2'd1;
                    end
                end
            endcase
        end

        for (int i = 0; i < 3; i++) begin
            step_res[i].last_in_run = (step_n == 2'(i + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_val  <= 16'd0;
            r_cnt  <= 3'd0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_cnt  <= n_cnt;
        end
    end

    // Result queue: up to three writes per accepted item, one read per cycle unless the output stalls.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < step_n) begin
                    r_fifo[r_tail + 2'(i)] <= step_res[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 2'd0;
            r_tail  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (in_acc) begin
                r_tail <= r_tail + step_n;
            end
            if (out_acc) begin
                r_head <= r_head + 2'd1;
            end
            r_count <= r_count + (in_acc ? {1'b0, step_n} : 3'd0) - {2'd0, out_acc};
        end
    end

    // Room for the largest burst of three results is needed before taking an item.
    assign o_in_stall    = (r_count > 3'd1);
    assign o_out_valid   = (r_count != 3'd0);
    assign o_out_byte    = r_fifo[r_head].out_byte;
    assign o_kind        = r_fifo[r_head].kind;
    assign o_failed      = r_fifo[r_head].failed;
    assign o_last_in_run = r_fifo[r_head].last_in_run;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH))
        else $error("result queue count exceeds its depth");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_marker |=> r_mode == MODE_NORMAL && r_cnt == 3'd0)
        else $error("end item did not return the decoder to normal mode");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_marker |-> step_n != 2'd0 && step_res[step_n - 2'd1].kind)
        else $error("end item did not produce a status result last");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_end_marker && r_mode == MODE_ERR |-> step_n == 2'd0)
        else $error("data produced while in error mode");

endmodule

`default_nettype wire

>>> bench/tb_string_escape_decoder_unit.sv
// Testbench for string_escape_decoder_unit: feeds byte strings closed by end items and checks
// every decoded byte and end-of-string status against a decoder kept inside the bench.
// Depends on sed_pkg and the string_escape_decoder_unit RTL.

module tb_string_escape_decoder_unit;
    import sed_pkg::*;

    // Decodes each accepted item on its own copy of the decoder state and keeps the results
    // still owed by the block, oldest first.
    class decoded_stream_checker;
        t_mode       mode;
        logic [15:0] esc_val;
        logic [2:0]  n_digits;
        t_result     pending_results[$];
        t_result     item_results[$];
        int          n_checked;
        int          n_status;
        int          n_fail_status;
        int          n_bad;

        function new();
            mode          = MODE_NORMAL;
            esc_val       = '0;
            n_digits      = '0;
            n_checked     = 0;
            n_status      = 0;
            n_fail_status = 0;
            n_bad         = 0;
        endfunction

        function void add_result(logic [7:0] b, logic is_status, logic fail);
            t_result r;
            r.out_byte    = b;
            r.kind        = is_status;
            r.failed      = fail;
            r.last_in_run = 1'b0;
            if (item_results.size() < 3)
                item_results.push_back(r);
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == CH_BSLASH)
                mode = MODE_ESC;
            else
                add_result(b, 1'b0, 1'b0);
        endfunction

        // Only exactly two or four hex digits form a valid escape.
        function void close_hex();
            if (n_digits == 3'd2) begin
                add_result(esc_val[7:0], 1'b0, 1'b0);
                mode = MODE_NORMAL;
            end else if (n_digits == 3'd4) begin
                add_result(esc_val[15:8], 1'b0, 1'b0);
                add_result(esc_val[7:0], 1'b0, 1'b0);
                mode = MODE_NORMAL;
            end else begin
                mode = MODE_ERR;
            end
        endfunction

        function void close_dec();
            if (esc_val > DEC_MAX) begin
                mode = MODE_ERR;
            end else begin
                add_result(esc_val[7:0], 1'b0, 1'b0);
                mode = MODE_NORMAL;
            end
        endfunction

        function void escape_byte(logic [7:0] b);
            mode = MODE_NORMAL;
            case (b)
                CH_N: add_result(CH_LF, 1'b0, 1'b0);
                CH_T: add_result(CH_TAB, 1'b0, 1'b0);
                CH_BSLASH, CH_DQUOTE, CH_SQUOTE: add_result(b, 1'b0, 1'b0);
                CH_LBRACE: begin
                    add_result(CH_BSLASH, 1'b0, 1'b0);
                    add_result(CH_LBRACE, 1'b0, 1'b0);
                end
                CH_X: begin
                    mode     = MODE_HEX;
                    esc_val  = '0;
                    n_digits = '0;
                end
                default: begin
                    if (b >= CH_0 && b <= CH_9) begin
                        mode     = MODE_DEC;
                        esc_val  = 16'(b - CH_0);
                        n_digits = 3'd1;
                    end
                end
            endcase
        endfunction

        function void decode_item(logic [7:0] b, logic endm);
            int         d;
            logic [3:0] nib;
            d   = -1;
            nib = '0;
            item_results.delete();
            if (endm) begin
                if (mode == MODE_HEX)
                    close_hex();
                else if (mode == MODE_DEC)
                    close_dec();
                add_result(8'h00, 1'b1, mode == MODE_ERR);
                mode     = MODE_NORMAL;
                esc_val  = '0;
                n_digits = '0;
            end else begin
                case (mode)
                    MODE_ESC: escape_byte(b);
                    MODE_HEX: begin
                        if (b >= CH_0 && b <= CH_9)
                            d = int'(b - CH_0);
                        else if (b >= CH_LA && b <= CH_LF_HEX)
                            d = int'(b - CH_LA) + 10;
                        else if (b >= CH_UA && b <= CH_UF)
                            d = int'(b - CH_UA) + 10;
                        if (d >= 0) begin
                            nib      = d[3:0];
                            esc_val  = {esc_val[11:0], nib};
                            n_digits = n_digits + 3'd1;
                            // A fifth digit can never form a valid escape.
                            if (n_digits >= 3'd5)
                                mode = MODE_ERR;
                        end else begin
                            close_hex();
                            if (mode != MODE_ERR)
                                plain_byte(b);
                        end
                    end
                    MODE_DEC: begin
                        if (b >= CH_0 && b <= CH_9) begin
                            esc_val  = esc_val * 16'd10 + 16'(b - CH_0);
                            n_digits = n_digits + 3'd1;
                            if (n_digits >= 3'd3)
                                close_dec();
                        end else begin
                            close_dec();
                            if (mode != MODE_ERR)
                                plain_byte(b);
                        end
                    end
                    MODE_ERR: ;
                    default: begin
                        mode = MODE_NORMAL;
                        plain_byte(b);
                    end
                endcase
            end
            if (item_results.size() > 0)
                item_results[item_results.size() - 1].last_in_run = 1'b1;
            foreach (item_results[k])
                pending_results.push_back(item_results[k]);
        endfunction

        function void check_output(t_result got);
            t_result want;
            n_checked++;
            if (pending_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected result %0d: byte=%h kind=%b failed=%b last=%b",
                             n_checked, got.out_byte, got.kind, got.failed, got.last_in_run);
                return;
            end
            want = pending_results.pop_front();
            if (want.kind) begin
                n_status++;
                if (want.failed)
                    n_fail_status++;
            end
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.failed !== want.failed || got.last_in_run !== want.last_in_run) begin
                n_bad++;
                if (n_bad <= 10)
                    $display({"ERROR: result %0d: expected byte=%h kind=%b failed=%b last=%b,",
                              " got byte=%h kind=%b failed=%b last=%b"}, n_checked,
                             want.out_byte, want.kind, want.failed, want.last_in_run,
                             got.out_byte, got.kind, got.failed, got.last_in_run);
            end
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_marker  = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_kind;
    logic       o_failed;
    logic       o_last_in_run;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int n_items       = 0;
    int n_strings     = 0;

    decoded_stream_checker decoder_chk;

    string_escape_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_end_marker  (i_end_marker),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_failed      (o_failed),
        .o_last_in_run (o_last_in_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            decoder_chk.check_output({o_out_byte, o_kind, o_failed, o_last_in_run});
    end

    // Called at a falling edge; returns at the falling edge after the item is taken, with
    // valid left high so that a following item goes out without a gap.
    task automatic send_item(input logic [7:0] b, input logic endm);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_in_byte    <= 8'($urandom);
            i_end_marker <= 1'($urandom);
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_end_marker <= endm;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decoder_chk.decode_item(b, endm);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], 1'b0);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (decoder_chk.pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // A string of random pieces: plain bytes, escapes of every sort (good and bad),
    // noise, and now and then a trailing backslash, closed by an end item.
    task automatic send_random_string();
        int         n_pieces;
        int         n_hex;
        int         n_dig;
        int         v;
        logic [7:0] b;
        n_pieces = $urandom_range(1, 6);
        repeat (n_pieces) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    do b = 8'($urandom); while (b == CH_BSLASH);
                    send_item(b, 1'b0);
                end
                2: begin
                    case ($urandom_range(0, 5))
                        0: b = CH_N;
                        1: b = CH_T;
                        2: b = CH_BSLASH;
                        3: b = CH_DQUOTE;
                        4: b = CH_SQUOTE;
                        default: b = CH_LBRACE;
                    endcase
                    send_item(CH_BSLASH, 1'b0);
                    send_item(b, 1'b0);
                end
                3, 4: begin
                    v = $urandom_range(0, 15);
                    if (v < 4)
                        n_hex = (v == 0) ? 0 : (v == 1) ? 1 : (v == 2) ? 3 : 5;
                    else
                        n_hex = (v < 10) ? 2 : 4;
                    send_item(CH_BSLASH, 1'b0);
                    send_item(CH_X, 1'b0);
                    repeat (n_hex) begin
                        v = $urandom_range(0, 15);
                        if (v < 10)
                            b = CH_0 + 8'(v);
                        else if ($urandom_range(0, 1) == 1)
                            b = CH_UA + 8'(v - 10);
                        else
                            b = CH_LA + 8'(v - 10);
                        send_item(b, 1'b0);
                    end
                end
                5, 6: begin
                    n_dig = $urandom_range(1, 3);
                    send_item(CH_BSLASH, 1'b0);
                    for (int k = 0; k < n_dig; k++) begin
                        // Keep most three-digit values in range; a few still overflow.
                        if (k == 0 && n_dig == 3)
                            b = CH_0 + 8'($urandom_range(0, 2));
                        else
                            b = CH_0 + 8'($urandom_range(0, 9));
                        send_item(b, 1'b0);
                    end
                end
                7: begin
                    send_item(CH_BSLASH, 1'b0);
                    send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                end
                8: send_item(8'($urandom), 1'b0);
                default: send_item(8'($urandom_range(CH_0, CH_UF)), 1'b0);
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            send_item(CH_BSLASH, 1'b0);
        send_item(8'($urandom), 1'b1);
        n_strings++;
    endtask

    initial begin
        int target;
        decoder_chk = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero and high bytes, brace escape, four-digit hex closed by a plain byte.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("\\{\\x4A7fG");
        send_item(8'h00, 1'b1);
        // Third decimal digit closes the escape and overflows.
        send_text("\\256");
        send_item(8'h00, 1'b1);
        // One hex digit cut short by the end item.
        send_text("\\xA");
        send_item(8'h00, 1'b1);
        // A high byte that is no digit, then a trailing backslash.
        send_item(8'hB5, 1'b0);
        send_text("\\");
        send_item(8'h00, 1'b1);
        n_strings = 4;
        wait_for_results();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = (p == 1) ? 63 : (p == 3) ? 37 : 0;
            snk_stall_pct = (p == 2) ? 63 : (p == 3) ? 37 : 0;
            target = n_items + 80;
            while (n_items < target)
                send_random_string();
            wait_for_results();
        end

        repeat (10) @(negedge i_clk);
        $display("Run covered %0d strings in %0d input items under four idle/stall profiles.",
                 n_strings, n_items);
        $display("Checked %0d results, %0d end-of-string reports, %0d of them failures.",
                 decoder_chk.n_checked, decoder_chk.n_status, decoder_chk.n_fail_status);
        if (decoder_chk.n_bad == 0 && decoder_chk.pending_results.size() == 0)
            $display("tb_string_escape_decoder_unit: PASS");
        else
            $display("tb_string_escape_decoder_unit: FAIL");
        $finish;
    end

    initial begin
        #200000;
        $display("ERROR: timeout with %0d results still outstanding",
                 decoder_chk.pending_results.size());
        $display("tb_string_escape_decoder_unit: FAIL");
        $finish;
    end

endmodule
